>>> rtl/lz78e_pkg.sv
package lz78e_pkg;

    // Field widths
    localparam int ID_W      = 12;
    localparam int SYM_W     = 8;
    localparam int KEY_W     = ID_W + SYM_W;
    localparam int WIDTH_W   = 4;
    localparam int MAX_WIDTH = 12;

    // Dictionary sizing: ids never exceed 4095, so the store needs no more than 4096 rows
    localparam int DICT_SIZE  = 4096;
    localparam int DICT_DEPTH = (DICT_SIZE < 4096) ? DICT_SIZE : 4096;
    localparam int ADDR_W     = $clog2(DICT_DEPTH);
    localparam int LIMIT_CAP  = DICT_DEPTH - 1;

    localparam logic [ID_W-1:0] MAX_PHRASES_RST = 12'd4095;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_key;
        logic [ADDR_W-1:0] rd_addr;
    } dict_req_t;

endpackage

>>> rtl/lz78e_if.sv
interface lz78e_byte_if;
    logic                           valid;
    logic                           ready;
    logic [lz78e_pkg::SYM_W-1:0]    symbol;
    logic                           last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface lz78e_code_if;
    logic                           valid;
    logic                           ready;
    logic [lz78e_pkg::ID_W-1:0]     phrase_index;
    logic [lz78e_pkg::WIDTH_W-1:0]  index_bits;
    logic [lz78e_pkg::SYM_W-1:0]    symbol_out;
    logic                           has_symbol;
    logic                           final_res;

    modport source (output valid, output phrase_index, output index_bits,
                    output symbol_out, output has_symbol, output final_res, input ready);
    modport sink   (input valid, input phrase_index, input index_bits,
                    input symbol_out, input has_symbol, input final_res, output ready);
endinterface

>>> rtl/lz78e_dict.sv
module lz78e_dict
(
    input  logic                          clk,
    input  lz78e_pkg::dict_req_t          req,
    output logic [lz78e_pkg::KEY_W-1:0]   rd_data
);

    logic [lz78e_pkg::KEY_W-1:0] mem [lz78e_pkg::DICT_DEPTH];

    // Write one phrase key
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_key;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[req.rd_addr];
    end

endmodule

>>> rtl/lz78_byte_encoder_top.sv
// LZ78 byte encoder.
// byte_ch carries one input item per message byte (symbol, last); code_ch
// carries the emitted codes (phrase_index in index_bits bits, optional byte,
// final_res on the last code of a message). max_phrases is written through
// cfg_wr_en / cfg_wr_data and caps dictionary growth. The user must write
// max_phrases only while the block is idle; the block does not enforce this.
// Each item is matched against the dictionary by a linear scan: one stored
// phrase is read and compared per cycle through a single comparator. After
// acceptance an item is scanned (skipped while the dictionary is empty, ended
// early on a hit) and then decided; a code, when one is produced, is valid on
// code_ch in the cycle the encoder turns ready again. Scan length follows the
// number of stored phrases; the dictionary memory has a single read port.
// A finished code sits in an output register; the encoder accepts the next
// byte while it waits, and stalls only if a second code is due before the
// receiver takes the first.
// Reset (rst_n low, asynchronous) empties the dictionary, returns to the
// root phrase with code width 0 and sets max_phrases to 4095. The last byte
// of a message does the same for the dictionary, phrase and width.
module lz78_byte_encoder_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    lz78e_byte_if.sink                      byte_ch,
    lz78e_code_if.source                    code_ch,
    input  logic                            cfg_wr_en,
    input  logic [lz78e_pkg::ID_W-1:0]      cfg_wr_data
);

    lz78e_pkg::state_t                  state_reg, state_next;
    logic [lz78e_pkg::SYM_W-1:0]        sym_reg, sym_next;
    logic                               last_reg, last_next;
    logic [lz78e_pkg::ID_W-1:0]         count_reg, count_next;
    logic [lz78e_pkg::ID_W-1:0]         cur_reg, cur_next;
    logic [lz78e_pkg::WIDTH_W-1:0]      width_reg, width_next;
    logic [lz78e_pkg::ID_W-1:0]         maxp_reg;
    logic [lz78e_pkg::ADDR_W-1:0]       scan_addr_reg, scan_addr_next;
    logic [lz78e_pkg::ADDR_W-1:0]       cmp_id_reg, cmp_id_next;
    logic                               cmp_valid_reg, cmp_valid_next;
    logic                               hit_reg, hit_next;
    logic [lz78e_pkg::ADDR_W-1:0]       hit_id_reg, hit_id_next;

    logic                               out_valid_reg, out_valid_next;
    logic [lz78e_pkg::ID_W-1:0]         out_index_reg, out_index_next;
    logic [lz78e_pkg::WIDTH_W-1:0]      out_bits_reg, out_bits_next;
    logic [lz78e_pkg::SYM_W-1:0]        out_sym_reg, out_sym_next;
    logic                               out_has_reg, out_has_next;
    logic                               out_final_reg, out_final_next;

    lz78e_pkg::dict_req_t               dict_req;
    logic [lz78e_pkg::KEY_W-1:0]        rd_data;
    logic [lz78e_pkg::KEY_W-1:0]        key;
    logic [lz78e_pkg::ID_W-1:0]         limit;
    logic [lz78e_pkg::ID_W-1:0]         count_plus;
    logic                               need_out;
    logic                               out_free;

    lz78e_dict u_dict
    (
        .clk     (clk),
        .req     (dict_req),
        .rd_data (rd_data)
    );

    assign key        = {cur_reg, sym_reg};
    assign limit      = (maxp_reg > lz78e_pkg::ID_W'(lz78e_pkg::LIMIT_CAP))
                        ? lz78e_pkg::ID_W'(lz78e_pkg::LIMIT_CAP) : maxp_reg;
    assign count_plus = count_reg + 1'b1;
    assign need_out   = !hit_reg || last_reg;
    assign out_free   = !out_valid_reg || code_ch.ready;

    assign byte_ch.ready        = (state_reg == lz78e_pkg::ST_IDLE);
    assign code_ch.valid        = out_valid_reg;
    assign code_ch.phrase_index = out_index_reg;
    assign code_ch.index_bits   = out_bits_reg;
    assign code_ch.symbol_out   = out_sym_reg;
    assign code_ch.has_symbol   = out_has_reg;
    assign code_ch.final_res    = out_final_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxp_reg <= lz78e_pkg::MAX_PHRASES_RST;
        end
        else if (cfg_wr_en)
        begin
            maxp_reg <= cfg_wr_data;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lz78e_pkg::ST_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            width_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            width_reg     <= width_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        last_reg      <= last_next;
        scan_addr_reg <= scan_addr_next;
        cmp_id_reg    <= cmp_id_next;
        hit_reg       <= hit_next;
        hit_id_reg    <= hit_id_next;
        out_index_reg <= out_index_next;
        out_bits_reg  <= out_bits_next;
        out_sym_reg   <= out_sym_next;
        out_has_reg   <= out_has_next;
        out_final_reg <= out_final_next;
    end

    // Sequencer: scan, decide, emit
    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        width_next     = width_reg;
        scan_addr_next = scan_addr_reg;
        cmp_id_next    = cmp_id_reg;
        cmp_valid_next = cmp_valid_reg;
        hit_next       = hit_reg;
        hit_id_next    = hit_id_reg;
        out_valid_next = out_valid_reg && !code_ch.ready;
        out_index_next = out_index_reg;
        out_bits_next  = out_bits_reg;
        out_sym_next   = out_sym_reg;
        out_has_next   = out_has_reg;
        out_final_next = out_final_reg;

        dict_req.wr_en   = 1'b0;
        dict_req.wr_addr = count_plus[lz78e_pkg::ADDR_W-1:0];
        dict_req.wr_key  = key;
        dict_req.rd_addr = scan_addr_reg;

        case (state_reg)
            lz78e_pkg::ST_IDLE:
            begin
                // Take an item; scan from phrase 1 unless no phrase is stored
                if (byte_ch.valid)
                begin
                    sym_next       = byte_ch.symbol;
                    last_next      = byte_ch.last;
                    scan_addr_next = lz78e_pkg::ADDR_W'(1);
                    cmp_valid_next = 1'b0;
                    hit_next       = 1'b0;
                    if (count_reg == '0)
                    begin
                        state_next = lz78e_pkg::ST_DECIDE;
                    end
                    else
                    begin
                        state_next = lz78e_pkg::ST_SCAN;
                    end
                end
            end

            lz78e_pkg::ST_SCAN:
            begin
                // Compare the entry read last cycle, read the next one
                if (cmp_valid_reg && (rd_data == key))
                begin
                    hit_next    = 1'b1;
                    hit_id_next = cmp_id_reg;
                    state_next  = lz78e_pkg::ST_DECIDE;
                end
                else if (cmp_valid_reg && (lz78e_pkg::ID_W'(cmp_id_reg) == count_reg))
                begin
                    hit_next   = 1'b0;
                    state_next = lz78e_pkg::ST_DECIDE;
                end
                else
                begin
                    cmp_id_next    = scan_addr_reg;
                    cmp_valid_next = 1'b1;
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end

            lz78e_pkg::ST_DECIDE:
            begin
                // Hold until the output register can take a code, when one is due
                if (!need_out || out_free)
                begin
                    state_next = lz78e_pkg::ST_IDLE;
                    if (need_out)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = hit_reg ? lz78e_pkg::ID_W'(hit_id_reg) : cur_reg;
                        out_bits_next  = width_reg;
                        out_sym_next   = hit_reg ? '0 : sym_reg;
                        out_has_next   = !hit_reg;
                        out_final_next = last_reg;
                    end
                    if (hit_reg)
                    begin
                        cur_next = lz78e_pkg::ID_W'(hit_id_reg);
                    end
                    else
                    begin
                        cur_next = '0;
                        // If room is left, add the phrase; widen code if needed
                        if (count_reg < limit)
                        begin
                            count_next     = count_plus;
                            dict_req.wr_en = 1'b1;
                            if ((width_reg < lz78e_pkg::WIDTH_W'(lz78e_pkg::MAX_WIDTH)) &&
                                ((13'd1 << width_reg) <= {1'b0, count_plus}))
                            begin
                                width_next = width_reg + 1'b1;
                            end
                        end
                    end
                    // Drop the dictionary at the end of a message
                    if (last_reg)
                    begin
                        count_next = '0;
                        cur_next   = '0;
                        width_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = lz78e_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/lz78e_checker.sv
module lz78e_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [lz78e_pkg::ID_W-1:0]      phrase_index,
    input  logic [lz78e_pkg::WIDTH_W-1:0]   index_bits,
    input  logic [lz78e_pkg::SYM_W-1:0]     symbol_out,
    input  logic                            has_symbol,
    input  logic                            final_res
);

    // A stalled code stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("code dropped while stalled");

    // A stalled code keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(phrase_index) && $stable(index_bits) &&
        $stable(symbol_out) && $stable(has_symbol) && $stable(final_res))
        else $error("code payload changed while stalled");

    // The encoder is busy right after taking a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready straight after an accepted byte");

    // A trailing index carries no byte and ends the message
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_symbol |-> (symbol_out == '0) && final_res)
        else $error("bad trailing index code");

    // Code width never exceeds twelve bits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> index_bits <= lz78e_pkg::WIDTH_W'(lz78e_pkg::MAX_WIDTH))
        else $error("index width out of range");

endmodule

bind lz78_byte_encoder_top lz78e_checker u_lz78e_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_ch.valid),
    .in_ready     (byte_ch.ready),
    .out_valid    (code_ch.valid),
    .out_ready    (code_ch.ready),
    .phrase_index (code_ch.phrase_index),
    .index_bits   (code_ch.index_bits),
    .symbol_out   (code_ch.symbol_out),
    .has_symbol   (code_ch.has_symbol),
    .final_res    (code_ch.final_res)
);
